FILE: hw/rtl/fda_pkg.sv
package fda_pkg;

    localparam int ORDER       = 31;
    localparam int NTAPS       = ORDER + 1;
    localparam int ALIGN_SKIP  = (ORDER + 1) / 2;

    localparam int SAMPLE_W   = 16;
    localparam int TAP_W      = 18;
    localparam int TAP_IDX_W  = 5;
    localparam int OPCODE_W   = 2;
    localparam int DELAY_W    = 7;
    localparam int FRAC_W     = 16;
    localparam int CNT_W      = (NTAPS > 1) ? $clog2(NTAPS) : 1;
    localparam int HIST_IDX_W = (ORDER > 1) ? $clog2(ORDER) : 1;
    localparam int PROD_W     = TAP_W + SAMPLE_W;
    localparam int ACC_W      = PROD_W + CNT_W;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;

    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7fff;

    typedef enum logic [OPCODE_W-1:0] {
        OP_FILTER = 2'd0,
        OP_FLUSH  = 2'd1,
        OP_LOAD   = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_FIN,
        ST_WAIT
    } state_t;

    typedef struct packed {
        logic first;
        logic add;
    } mac_ctl_t;

endpackage

FILE: hw/rtl/fda_mac.sv
module fda_mac (
    input  logic                                   clk,
    input  fda_pkg::mac_ctl_t                      ctl,
    input  logic signed [fda_pkg::TAP_W-1:0]       tap,
    input  logic signed [fda_pkg::SAMPLE_W-1:0]    smp,
    output logic signed [fda_pkg::SAMPLE_W-1:0]    result
);
    import fda_pkg::*;

    logic signed [PROD_W-1:0]         prod_reg;
    logic signed [ACC_W-1:0]          acc_reg;
    logic signed [ACC_W-1:0]          acc_next;
    logic signed [ACC_W-1:0]          acc_adj;
    logic signed [ACC_W-FRAC_W-1:0]   quot;

    always_comb
    begin
        if (ctl.first)
        begin
            acc_next = '0;
        end
        else if (ctl.add)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= tap * smp;
        acc_reg  <= acc_next;
    end

    // truncate toward zero, then saturate
    always_comb
    begin
        acc_adj = acc_reg + (acc_reg[ACC_W-1] ? ACC_W'((1 << FRAC_W) - 1) : ACC_W'(0));
        quot    = acc_adj[ACC_W-1:FRAC_W];
        if (quot < (ACC_W-FRAC_W)'(SAT_MIN))
        begin
            result = SAT_MIN;
        end
        else if (quot > (ACC_W-FRAC_W)'(SAT_MAX))
        begin
            result = SAT_MAX;
        end
        else
        begin
            result = quot[SAMPLE_W-1:0];
        end
    end

endmodule

FILE: hw/rtl/fir_filter_delay_aligned.sv
// delay-aligned fir filter, 32 taps, signed 16-bit samples, q2.16 coefficients
// input stream: tuser carries the opcode (filter, flush, load coefficient),
// tdata carries sample_in, tap_index and tap_value
// output stream: tdata carries sample_out, tlast marks the final word of an item
// the first NTAPS / 2 samples after reset only fill the history, no output
// a flush item replays one zero sample per swallowed sample, up to NTAPS / 2, one word each
// one shared multiplier-accumulator walks the taps, one tap per cycle
// a filtered word passes the mac, drain and finish states after its input is taken
// and then waits until the receiver takes it
// the next input is taken in the cycle after that at the earliest
// a flush runs those states again for each further word once the previous one is taken
// load and swallowed samples are handled in idle and start no mac pass
// s_axis_tready is high only while idle, so while m_axis stalls no input is taken
// reset clears history, coefficients and the output valid and last flags, and restarts the delay count
module fir_filter_delay_aligned (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [fda_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // sample_in, tap_index, tap_value
    input  logic [fda_pkg::OPCODE_W-1:0]       s_axis_tuser,  // opcode
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [fda_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // sample_out
    output logic                               m_axis_tlast
);
    import fda_pkg::*;

    state_t                       state_reg, state_next;
    logic signed [SAMPLE_W-1:0]   hist_reg [ORDER];
    logic signed [SAMPLE_W-1:0]   hist_next [ORDER];
    logic signed [TAP_W-1:0]      tap_reg [NTAPS];
    logic [DELAY_W-1:0]           delay_reg, delay_next;
    logic [DELAY_W-1:0]           remain_reg, remain_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic signed [SAMPLE_W-1:0]   x_reg, x_next;
    logic signed [SAMPLE_W-1:0]   out_data_reg, out_data_next;
    logic                         out_last_reg, out_last_next;
    logic                         out_valid_reg, out_valid_next;

    logic                         in_fire;
    logic                         shift_en;
    logic signed [SAMPLE_W-1:0]   shift_val;
    logic                         tap_we;
    logic [CNT_W-1:0]             cnt_m1;
    logic [DELAY_W-1:0]           flush_cnt;
    logic signed [SAMPLE_W-1:0]   smp;
    logic signed [SAMPLE_W-1:0]   mac_result;
    mac_ctl_t                     mac_ctl;
    opcode_t                      opcode;

    logic signed [SAMPLE_W-1:0]   sample_in;
    logic [TAP_IDX_W-1:0]         tap_index;
    logic signed [TAP_W-1:0]      tap_value;

    assign sample_in = s_axis_tdata[SAMPLE_W-1:0];
    assign tap_index = s_axis_tdata[SAMPLE_W+TAP_IDX_W-1:SAMPLE_W];
    assign tap_value = s_axis_tdata[SAMPLE_W+TAP_IDX_W+TAP_W-1:SAMPLE_W+TAP_IDX_W];
    assign opcode    = opcode_t'(s_axis_tuser);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign flush_cnt     = DELAY_W'(ALIGN_SKIP) - delay_reg;
    assign tap_we        = in_fire && (opcode == OP_LOAD) && (int'(tap_index) < NTAPS);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // sample for tap k: new sample at k = 0, else history entry k - 1
    assign cnt_m1 = cnt_reg - CNT_W'(1);
    assign smp    = (cnt_reg == '0) ? x_reg : hist_reg[cnt_m1[HIST_IDX_W-1:0]];

    assign mac_ctl.first = (state_reg == ST_MAC) && (cnt_reg == '0);
    assign mac_ctl.add   = (state_reg == ST_MAC) || (state_reg == ST_DRAIN);

    fda_mac u_mac (
        .clk    (clk),
        .ctl    (mac_ctl),
        .tap    (tap_reg[cnt_reg]),
        .smp    (smp),
        .result (mac_result)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if ((opcode == OP_FILTER) && (delay_reg == '0))
                    begin
                        state_next = ST_MAC;
                    end
                    else if ((opcode == OP_FLUSH) && (flush_cnt != '0))
                    begin
                        state_next = ST_MAC;
                    end
                end
            end
            ST_MAC:
            begin
                if (cnt_reg == CNT_W'(NTAPS - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (m_axis_tready)
                begin
                    state_next = (remain_reg != '0) ? ST_MAC : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        delay_next     = delay_reg;
        remain_next    = remain_reg;
        cnt_next       = cnt_reg;
        x_next         = x_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg;
        shift_en       = 1'b0;
        shift_val      = x_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_fire)
                begin
                    case (opcode)
                        OP_FILTER:
                        begin
                            if (delay_reg != '0)
                            begin
                                shift_en   = 1'b1;
                                shift_val  = sample_in;
                                delay_next = delay_reg - DELAY_W'(1);
                            end
                            else
                            begin
                                x_next      = sample_in;
                                remain_next = '0;
                            end
                        end
                        OP_FLUSH:
                        begin
                            x_next      = '0;
                            remain_next = flush_cnt - DELAY_W'(1);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_MAC:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_DRAIN:
            begin
                cnt_next = '0;
            end
            ST_FIN:
            begin
                out_data_next  = mac_result;
                out_last_next  = (remain_reg == '0);
                out_valid_next = 1'b1;
                shift_en       = 1'b1;
                shift_val      = x_reg;
            end
            ST_WAIT:
            begin
                if (m_axis_tready)
                begin
                    out_valid_next = 1'b0;
                    if (remain_reg != '0)
                    begin
                        remain_next = remain_reg - DELAY_W'(1);
                        x_next      = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // history shift line
    always_comb
    begin
        for (int i = 0; i < ORDER; i++)
        begin
            hist_next[i] = hist_reg[i];
        end
        if (shift_en)
        begin
            hist_next[0] = shift_val;
            for (int i = 1; i < ORDER; i++)
            begin
                hist_next[i] = hist_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            delay_reg     <= DELAY_W'(ALIGN_SKIP);
            remain_reg    <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            for (int i = 0; i < ORDER; i++)
            begin
                hist_reg[i] <= '0;
            end
            for (int i = 0; i < NTAPS; i++)
            begin
                tap_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            delay_reg     <= delay_next;
            remain_reg    <= remain_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
            for (int i = 0; i < ORDER; i++)
            begin
                hist_reg[i] <= hist_next[i];
            end
            if (tap_we)
            begin
                tap_reg[CNT_W'(tap_index)] <= tap_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        out_data_reg <= out_data_next;
    end

    a_idle_no_output: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input taken while an output word is pending");

    a_delay_range: assert property (@(posedge clk) disable iff (!rst_n)
        delay_reg <= DELAY_W'(ALIGN_SKIP))
        else $error("delay count above alignment skip");

    a_drain_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |=> (state_reg == ST_FIN))
        else $error("drain not followed by finish");

    a_last_matches: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (remain_reg == '0)))
        else $error("tlast does not match remaining flush count");

endmodule

FILE: tb/fda_checker.sv
`timescale 1ns / 1ps

module fda_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [fda_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [fda_pkg::OPCODE_W-1:0]   s_axis_tuser,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [fda_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                           m_axis_tlast,
    output int                             errors,
    output int                             pending
);
    import fda_pkg::*;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } filtered_word_t;

    logic signed [SAMPLE_W-1:0] history [ORDER];
    logic signed [TAP_W-1:0]    coefs [NTAPS];
    int                         swallow_left;
    filtered_word_t             expected_words [$];

    function automatic void shift_history(input logic signed [SAMPLE_W-1:0] x);
        int k;
        for (k = ORDER - 1; k > 0; k--)
            history[k] = history[k-1];
        history[0] = x;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] filter_sample(
        input logic signed [SAMPLE_W-1:0] x
    );
        longint acc;
        longint q;
        int     k;
        acc = longint'(coefs[0]) * longint'(x);
        for (k = 0; k < ORDER; k++)
            acc += longint'(coefs[k+1]) * longint'(history[k]);
        shift_history(x);
        // truncates toward zero
        q = acc / 65536;
        if (q < SAT_MIN)
            q = SAT_MIN;
        if (q > SAT_MAX)
            q = SAT_MAX;
        return q[SAMPLE_W-1:0];
    endfunction

    function automatic void push_word(input logic signed [SAMPLE_W-1:0] y, input logic last);
        filtered_word_t w;
        w.sample = y;
        w.last   = last;
        expected_words.push_back(w);
    endfunction

    always @(posedge clk)
    begin
        filtered_word_t             want;
        logic signed [SAMPLE_W-1:0] x;
        logic [TAP_IDX_W-1:0]       idx;
        int                         n;
        int                         k;
        if (!rst_n)
        begin
            for (k = 0; k < ORDER; k++)
                history[k] = '0;
            for (k = 0; k < NTAPS; k++)
                coefs[k] = '0;
            swallow_left = ALIGN_SKIP;
            expected_words.delete();
            errors <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_words.size() == 0)
                begin
                    if (errors < 10)
                        $display("%0t: word %h last %b with none expected",
                                 $realtime, m_axis_tdata, m_axis_tlast);
                    errors <= errors + 1;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (m_axis_tdata !== want.sample || m_axis_tlast !== want.last)
                    begin
                        if (errors < 10)
                            $display("%0t: mismatch: expected %0d last %b, got %0d last %b",
                                     $realtime, want.sample, want.last,
                                     $signed(m_axis_tdata), m_axis_tlast);
                        errors <= errors + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                case (opcode_t'(s_axis_tuser))
                    OP_FILTER:
                    begin
                        x = s_axis_tdata[SAMPLE_W-1:0];
                        if (swallow_left > 0)
                        begin
                            shift_history(x);
                            swallow_left--;
                        end
                        else
                            push_word(filter_sample(x), 1'b1);
                    end
                    OP_FLUSH:
                    begin
                        n = ALIGN_SKIP - swallow_left;
                        for (k = 0; k < n; k++)
                            push_word(filter_sample('0), k == n - 1);
                    end
                    OP_LOAD:
                    begin
                        idx = s_axis_tdata[SAMPLE_W +: TAP_IDX_W];
                        if (idx < NTAPS)
                            coefs[idx] = s_axis_tdata[SAMPLE_W + TAP_IDX_W +: TAP_W];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        pending <= expected_words.size();
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

    import fda_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 5000;
    localparam int FILTER_ITEMS = 450;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [OPCODE_W-1:0]   s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    int                    errors;
    int                    pending;
    int                    idle_cycles;
    int                    send_calm;

    fir_filter_delay_aligned i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    fda_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .errors        (errors),
        .pending       (pending)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return SAT_MAX;
        if (r < 20)
            return SAT_MIN;
        if (r < 25)
            return '0;
        if (r < 30)
            return -16'sd1;
        return SAMPLE_W'($urandom());
    endfunction

    function automatic logic signed [TAP_W-1:0] pick_tap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 18'sh1ffff;
        if (r < 10)
            return 18'sh20000;
        if (r < 50)
            return TAP_W'($urandom());
        return TAP_W'($signed($urandom_range(0, 16383)) - 8192);
    endfunction

    task automatic push_item(
        input logic [OPCODE_W-1:0]       op,
        input logic signed [SAMPLE_W-1:0] smp,
        input logic [TAP_IDX_W-1:0]      idx,
        input logic signed [TAP_W-1:0]    tap
    );
        int gap;
        int r;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {1'b0, tap, idx, smp};
        do
            @(posedge clk);
        while (!s_axis_tready);
        gap = 0;
        if (send_calm > 0)
            send_calm--;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
                send_calm = $urandom_range(20, 60);
            else if (r < 50)
                gap = 0;
            else if (r < 88)
                gap = $urandom_range(1, 3);
            else
                gap = $urandom_range(10, 50);
        end
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp);
        push_item(OP_FILTER, smp, TAP_IDX_W'($urandom()), TAP_W'($urandom()));
    endtask

    task automatic send_flush();
        push_item(OP_FLUSH, SAMPLE_W'($urandom()), TAP_IDX_W'($urandom()),
                  TAP_W'($urandom()));
    endtask

    task automatic send_load(input logic [TAP_IDX_W-1:0] idx, input logic signed [TAP_W-1:0] tap);
        push_item(OP_LOAD, SAMPLE_W'($urandom()), idx, tap);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // receiver: random stalls, calm stretches, two long holds to back up the filter
    initial
    begin
        int stall_left;
        int calm_left;
        int taken;
        int next_hold;
        m_axis_tready = 1'b0;
        stall_left = 0;
        calm_left = 0;
        taken = 0;
        next_hold = 40;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                taken++;
            if (stall_left == 0)
            begin
                if (taken >= next_hold)
                begin
                    stall_left = 600;
                    next_hold = (next_hold == 40) ? 240 : 32'h7fffffff;
                end
                else if (calm_left > 0)
                    calm_left--;
                else
                begin
                    case ($urandom_range(0, 99)) inside
                        [0:7]:   calm_left = $urandom_range(50, 150);
                        [8:39]:  stall_left = $urandom_range(1, 3);
                        [40:43]: stall_left = $urandom_range(20, 80);
                        default: stall_left = 0;
                    endcase
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        int i;
        int r;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_FILTER;
        send_calm = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_load(5'd0, 18'sh1ffff);
        send_load(5'd31, 18'sh20000);
        send_load(5'd1, 18'sh10000);
        send_load(5'd16, -18'sd1);
        // flush with nothing swallowed yet gives no word
        send_flush();
        push_item(OP_UNUSED, SAMPLE_W'($urandom()), TAP_IDX_W'($urandom()),
                  TAP_W'($urandom()));
        send_sample(SAT_MAX);
        send_sample(SAT_MIN);
        send_sample('0);
        send_sample(-16'sd1);
        // partial flush while still in the delay
        send_flush();
        for (i = 0; i < ALIGN_SKIP - 4; i++)
            send_sample(pick_sample());
        send_sample(SAT_MAX);
        send_sample(SAT_MIN);
        send_flush();
        drain_results();

        for (i = 0; i < FILTER_ITEMS; i++)
        begin
            if (i == FILTER_ITEMS / 2)
                drain_results();
            r = $urandom_range(0, 99);
            if (r < 70)
                send_sample(pick_sample());
            else if (r < 92)
                send_load(TAP_IDX_W'($urandom_range(0, NTAPS - 1)), pick_tap());
            else if (r < 98)
                send_flush();
            else
                push_item(OP_UNUSED, SAMPLE_W'($urandom()), TAP_IDX_W'($urandom()),
                          TAP_W'($urandom()));
        end

        drain_results();
        repeat (100) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
